@@ sv/sbpc_pkg.sv @@
// Package for the six-bit printable codec.
// Holds the result and queue entry types, the character offset, the default queue depth and the mode codes.
// No dependencies.
`default_nettype none

package sbpc_pkg;

    // Offset added to every six-bit group on the character side
    localparam logic [7:0] OFFSET_CHAR = 8'h3c;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    // One result item as seen on the output channel
    typedef struct packed {
        logic [7:0] data_out;
        logic       has_data;
        logic       bad_char;
        logic       end_of_output;
    } t_result;

    // Work for the back end: one result, or two when two is set
    typedef struct packed {
        t_result first;
        logic    two;
        t_result second;
    } t_entry;

endpackage

`default_nettype wire

@@ sv/sbpc_if.sv @@
// Channel interfaces of the six-bit printable codec: input, output and mode write.
// Valid/ready handshake; a transfer happens when both are high at a clock edge.
// No dependencies.
`default_nettype none

interface sbpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_in;
    logic       end_of_input;

    modport source (output valid, output data_in, output end_of_input, input ready);
    modport sink (input valid, input data_in, input end_of_input, output ready);
endinterface

interface sbpc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       has_data;
    logic       bad_char;
    logic       end_of_output;

    modport source (output valid, output data_out, output has_data, output bad_char,
                    output end_of_output, input ready);
    modport sink (input valid, input data_out, input has_data, input bad_char,
                  input end_of_output, output ready);
endinterface

interface sbpc_cfg_if;
    logic valid;
    logic ready;
    logic mode;

    modport source (output valid, output mode, input ready);
    modport sink (input valid, input mode, output ready);
endinterface

`default_nettype wire

@@ sv/sbpc_front.sv @@
// Front end of the six-bit printable codec: takes input transfers and mode writes,
// keeps the stream state and turns each item into a queue entry of up to two results.
// Depends on sbpc_pkg and sbpc_if.
`default_nettype none

module sbpc_front
    import sbpc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sbpc_in_if.sink     i_in,
    sbpc_cfg_if.sink    i_cfg,
    input  wire logic   i_q_ready,
    output logic        o_push,
    output t_entry      o_entry
);

    t_mode      r_mode, n_mode;
    logic [5:0] r_enc_rest, n_enc_rest;
    logic [1:0] r_enc_phase, n_enc_phase;
    logic [1:0] r_dec_offset, n_dec_offset;
    logic [2:0] r_dec_filled, n_dec_filled;
    logic [7:0] r_dec_partial, n_dec_partial;
    logic       r_failed, n_failed;

    logic       accept;
    logic       last;
    logic [7:0] b;
    logic [1:0] enc_p;
    logic [5:0] made;
    logic [5:0] rest;
    logic [7:0] diff;
    logic [5:0] g;
    logic [1:0] dec_p;
    logic       have;
    logic       wrap;
    logic [1:0] new_p;
    logic [7:0] dec_byte;
    logic [7:0] partial_new;
    logic [2:0] filled_base;
    logic [2:0] filled_new;

    function automatic t_result mk_result(logic [7:0] d, logic h, logic bad, logic e);
        t_result r;
        r.data_out      = d;
        r.has_data      = h;
        r.bad_char      = bad;
        r.end_of_output = e;
        return r;
    endfunction

    assign i_in.ready  = i_q_ready;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid & i_q_ready;
    assign last        = i_in.end_of_input;
    assign b           = i_in.data_in;

    // Encoder: split the byte at the current phase
    always_comb begin
        enc_p = (r_enc_phase > 2'd2) ? 2'd2 : r_enc_phase;
        unique case (enc_p)
            2'd0: begin
                made = b[7:2];
                rest = {b[1:0], 4'b0000};
            end
            2'd1: begin
                made = r_enc_rest | {2'b00, b[7:4]};
                rest = {b[3:0], 2'b00};
            end
            default: begin
                made = r_enc_rest | {4'b0000, b[7:6]};
                rest = b[5:0];
            end
        endcase
    end

    // Decoder: finish the pending byte and start the next one
    always_comb begin
        diff  = b - OFFSET_CHAR;
        g     = diff[5:0];
        dec_p = (r_dec_offset > 2'd2) ? 2'd2 : r_dec_offset;
        have  = (r_dec_filled >= 3'd2);
        wrap  = have && (dec_p == 2'd2);
        new_p = (have && !wrap) ? dec_p + 2'd1 : dec_p;
        unique case (dec_p)
            2'd0:    dec_byte = r_dec_partial | {6'b000000, g[5:4]};
            2'd1:    dec_byte = r_dec_partial | {4'b0000, g[5:2]};
            default: dec_byte = r_dec_partial | {2'b00, g};
        endcase
        filled_base = have ? 3'd0 : r_dec_filled;
        unique case (new_p)
            2'd0: begin
                partial_new = {g, 2'b00};
                filled_new  = filled_base + 3'd6;
            end
            2'd1: begin
                partial_new = {g[3:0], 4'b0000};
                filled_new  = filled_base + 3'd4;
            end
            default: begin
                partial_new = {g[1:0], 6'b000000};
                filled_new  = filled_base + 3'd2;
            end
        endcase
    end

    // Next state and queue entry
    always_comb begin
        n_mode        = r_mode;
        n_enc_rest    = r_enc_rest;
        n_enc_phase   = r_enc_phase;
        n_dec_offset  = r_dec_offset;
        n_dec_filled  = r_dec_filled;
        n_dec_partial = r_dec_partial;
        n_failed      = r_failed;
        o_push        = 1'b0;
        o_entry       = '0;

        if (accept) begin
            if (r_mode == MODE_ENCODE) begin
                o_push        = 1'b1;
                o_entry.first = mk_result({2'b00, made} + OFFSET_CHAR, 1'b1, 1'b0, 1'b0);
                if (enc_p == 2'd2) begin
                    o_entry.two    = 1'b1;
                    o_entry.second = mk_result({2'b00, rest} + OFFSET_CHAR, 1'b1, 1'b0, last);
                    n_enc_phase    = 2'd0;
                    n_enc_rest     = 6'd0;
                end else begin
                    // flush leftover bits after the last byte
                    o_entry.two    = last;
                    o_entry.second = mk_result({2'b00, rest} + OFFSET_CHAR, 1'b1, 1'b0, 1'b1);
                    n_enc_phase    = enc_p + 2'd1;
                    n_enc_rest     = rest;
                end
            end else begin
                if (r_failed) begin
                    o_push        = last;
                    o_entry.first = mk_result(8'h00, 1'b0, 1'b1, 1'b1);
                end else if (b < OFFSET_CHAR) begin
                    n_failed      = 1'b1;
                    o_push        = 1'b1;
                    o_entry.first = mk_result(8'h00, 1'b0, 1'b1, last);
                end else begin
                    if (wrap) begin
                        n_dec_offset  = 2'd0;
                        n_dec_partial = 8'h00;
                        n_dec_filled  = 3'd0;
                    end else begin
                        n_dec_offset  = new_p;
                        n_dec_partial = partial_new;
                        n_dec_filled  = filled_new;
                    end
                    o_push = have | last;
                    if (have) begin
                        o_entry.first = mk_result(dec_byte, 1'b1, 1'b0, last);
                    end else begin
                        o_entry.first = mk_result(8'h00, 1'b0, 1'b0, 1'b1);
                    end
                end
            end
        end

        // end of stream or mode write: fresh stream
        if ((accept && last) || i_cfg.valid) begin
            n_enc_rest    = 6'd0;
            n_enc_phase   = 2'd0;
            n_dec_offset  = 2'd0;
            n_dec_filled  = 3'd0;
            n_dec_partial = 8'h00;
            n_failed      = 1'b0;
        end
        if (i_cfg.valid) begin
            n_mode = t_mode'(i_cfg.mode);
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_ENCODE;
            r_enc_rest    <= 6'd0;
            r_enc_phase   <= 2'd0;
            r_dec_offset  <= 2'd0;
            r_dec_filled  <= 3'd0;
            r_dec_partial <= 8'h00;
            r_failed      <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_enc_rest    <= n_enc_rest;
            r_enc_phase   <= n_enc_phase;
            r_dec_offset  <= n_dec_offset;
            r_dec_filled  <= n_dec_filled;
            r_dec_partial <= n_dec_partial;
            r_failed      <= n_failed;
        end
    end

    // Encoder phase stays within a 3-byte block
    a_enc_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_enc_phase != 2'd3)
        else $error("encoder phase out of range");

    // Decoder holds an even bit count, and none only at the block start
    a_dec_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dec_filled[0] == 1'b0) && (r_dec_filled != 3'd0 || r_dec_offset == 2'd0))
        else $error("decoder fill count inconsistent");

    // A last item leaves a fresh stream behind
    a_stream_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> (r_enc_phase == 2'd0 && r_dec_filled == 3'd0 && !r_failed))
        else $error("stream state not cleared after last item");

endmodule

`default_nettype wire

@@ sv/sbpc_queue.sv @@
// Short queue between front and back of the six-bit printable codec.
// Each entry holds up to two results of one input item.
// Depends on sbpc_pkg.
`default_nettype none

module sbpc_queue
    import sbpc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_ready,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_entry      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/sbpc_back.sv @@
// Back end of the six-bit printable codec: takes queue entries and sends their
// results, one per output transfer, from a registered output stage.
// Depends on sbpc_pkg and sbpc_if.
`default_nettype none

module sbpc_back
    import sbpc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    input  wire t_entry i_q_head,
    output logic        o_pop,
    sbpc_out_if.source  o_out
);

    logic    r_valid;
    t_result r_res;
    logic    r_sub;
    logic    load;

    // Output stage is free when empty or its result is taken now
    assign load  = !r_valid || o_out.ready;
    assign o_pop = load && i_q_valid && (r_sub || !i_q_head.two);

    assign o_out.valid         = r_valid;
    assign o_out.data_out      = r_res.data_out;
    assign o_out.has_data      = r_res.has_data;
    assign o_out.bad_char      = r_res.bad_char;
    assign o_out.end_of_output = r_res.end_of_output;

    // Control: valid flag and which result of the head entry goes next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_sub <= !r_sub && i_q_head.two;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_res <= r_sub ? i_q_head.second : i_q_head.first;
        end
    end

endmodule

`default_nettype wire

@@ sv/six_bit_printable_codec.sv @@
// Top level of the six-bit printable codec: front end, queue and back end.
// Depends on sbpc_pkg, sbpc_if, sbpc_front, sbpc_queue and sbpc_back.
//
//  channel  dir  modport  payload
//  i_in     in   sink     data_in[7:0], end_of_input
//  o_out    out  source   data_out[7:0], has_data, bad_char, end_of_output
//  i_cfg    in   sink     mode (write channel, always ready)
//
// An input transfer is taken every cycle while the queue has room; its first result
// is offered on o_out at the earliest after it has passed through the queue and then
// the output register.
// An encoded byte that yields two characters holds the output for both of them,
// so the output port sets the rate: one result per cycle while o_out.ready is high.
// Reset (synchronous, active low) sets encode mode and a fresh stream.
// Output stalls back up through the queue to i_in.ready; mode writes clear the stream.
`default_nettype none

module six_bit_printable_codec
    import sbpc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sbpc_in_if.sink     i_in,
    sbpc_cfg_if.sink    i_cfg,
    sbpc_out_if.source  o_out
);

    logic   push;
    t_entry push_entry;
    logic   q_ready;
    logic   pop;
    logic   q_valid;
    t_entry q_head;

    sbpc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    sbpc_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    sbpc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

@@ bench/sbpc_check.sv @@
`timescale 1ns / 100ps
// Result checker for the six-bit printable codec: watches the input, mode and output
// channels, predicts each result of the codec and compares it field by field.
// Depends on sbpc_pkg and the channel interfaces of sbpc_if.

module sbpc_check
    import sbpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sbpc_in_if   i_in,
    sbpc_cfg_if  i_cfg,
    sbpc_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);

    // Predicted codec state
    t_mode      codec_mode;
    logic [5:0] enc_rest;
    logic [1:0] enc_phase;
    logic [1:0] dec_phase;
    logic [2:0] dec_filled;
    logic [7:0] dec_partial;
    logic       stream_failed;

    // Results predicted but not yet seen on the output
    t_result    due_results[$];
    int         fail_count = 0;
    int         pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic void clear_stream();
        enc_rest      = '0;
        enc_phase     = '0;
        dec_phase     = '0;
        dec_filled    = '0;
        dec_partial   = '0;
        stream_failed = 1'b0;
    endfunction

    function automatic void add_result(logic [7:0] data, logic has, logic bad, logic fin);
        t_result r;
        r.data_out      = data;
        r.has_data      = has;
        r.bad_char      = bad;
        r.end_of_output = fin;
        due_results.push_back(r);
    endfunction

    // Six-bit groups out of bytes: three bytes give four characters
    function automatic void encode_byte(logic [7:0] b, logic last);
        int unsigned ph;
        logic [5:0]  made;
        logic [5:0]  rest;
        ph   = (enc_phase > 2) ? 2 : enc_phase;
        made = enc_rest | 6'(b >> (2 + 2 * ph));
        rest = 6'(b << (4 - 2 * ph));
        if (ph == 2) begin
            add_result({2'b00, made} + OFFSET_CHAR, 1'b1, 1'b0, 1'b0);
            add_result({2'b00, rest} + OFFSET_CHAR, 1'b1, 1'b0, last);
            enc_phase = '0;
            enc_rest  = '0;
        end else begin
            enc_phase = 2'(ph + 1);
            enc_rest  = rest;
            add_result({2'b00, made} + OFFSET_CHAR, 1'b1, 1'b0, 1'b0);
            // leftover bits flushed as one more character
            if (last)
                add_result({2'b00, rest} + OFFSET_CHAR, 1'b1, 1'b0, 1'b1);
        end
    endfunction

    // Characters back into bytes, most significant bits first
    function automatic void decode_char(logic [7:0] c, logic last);
        int unsigned ph;
        int unsigned sh;
        logic [5:0]  grp;
        logic [7:0]  byte_out;
        logic        have;
        have     = 1'b0;
        byte_out = '0;
        if (stream_failed) begin
            if (last)
                add_result(8'h00, 1'b0, 1'b1, 1'b1);
        end else if (c < OFFSET_CHAR) begin
            stream_failed = 1'b1;
            add_result(8'h00, 1'b0, 1'b1, last);
        end else begin
            grp = 6'(c - OFFSET_CHAR);
            ph  = (dec_phase > 2) ? 2 : dec_phase;
            if (dec_filled >= 2) begin
                sh         = 2 + 2 * ph;
                byte_out   = dec_partial | 8'({2'b00, grp} >> (6 - sh));
                have       = 1'b1;
                dec_filled = '0;
                if (ph < 2) begin
                    ph        = ph + 1;
                    dec_phase = 2'(ph);
                end else begin
                    dec_phase   = '0;
                    dec_partial = '0;
                    ph          = 3;
                end
            end
            if (ph < 3) begin
                sh          = 2 + 2 * ph;
                dec_partial = 8'({2'b00, grp} << sh);
                dec_filled  = dec_filled + 3'(8 - sh);
            end
            if (have)
                add_result(byte_out, 1'b1, 1'b0, last);
            else if (last)
                add_result(8'h00, 1'b0, 1'b0, 1'b1);
        end
    endfunction

    function automatic void step_codec(logic [7:0] d, logic last);
        if (codec_mode == MODE_ENCODE)
            encode_byte(d, last);
        else
            decode_char(d, last);
        if (last)
            clear_stream();
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Sample all channels at the rising edge; results first, then new work
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            codec_mode = MODE_ENCODE;
            clear_stream();
            due_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result: data_out %0h has_data %0b bad_char %0b end %0b",
                           i_out.data_out, i_out.has_data, i_out.bad_char,
                           i_out.end_of_output);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("data_out", want.data_out, i_out.data_out);
                    check_field("has_data", want.has_data, i_out.has_data);
                    check_field("bad_char", want.bad_char, i_out.bad_char);
                    check_field("end_of_output", want.end_of_output, i_out.end_of_output);
                end
            end
            // a mode write starts a fresh stream
            if (i_cfg.valid && i_cfg.ready) begin
                codec_mode = t_mode'(i_cfg.mode);
                clear_stream();
            end
            if (i_in.valid && i_in.ready)
                step_codec(i_in.data_in, i_in.end_of_input);
        end
        pending_count = due_results.size();
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the six-bit printable codec bench: clock, reset, stimulus and verdict.
// Depends on sbpc_pkg, sbpc_if, six_bit_printable_codec and sbpc_check.

module tb_top;
    import sbpc_pkg::*;

    localparam real HALF_PERIOD   = 6.0;
    localparam int  RESET_CYCLES  = 7;
    localparam int  RANDOM_ITEMS  = 750;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  HOLD_CYCLES   = 80;
    localparam int  CYCLE_LIMIT   = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_sent  = 0;
    int   burst_left  = 0;
    int   cycle_count = 0;
    bit   hold_req    = 1'b0;

    sbpc_in_if  in_ch ();
    sbpc_out_if out_ch ();
    sbpc_cfg_if cfg_ch ();

    six_bit_printable_codec uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    sbpc_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // One input transfer; bursts of random length with random gaps between them
    task automatic send_char(input logic [7:0] d, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_in      <= d;
        in_ch.end_of_input <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // Stop sending and wait out every result plus any silent decode work
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input t_mode m);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.mode  <= m;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Next input: any byte for encode; for decode mostly legal characters, some bad ones, some anything
    function automatic logic [7:0] next_input(t_mode m);
        int r;
        if (m == MODE_ENCODE)
            return 8'($urandom_range(0, 255));
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'($urandom_range(0, 8'h3b));
        if (r == 1)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h3c, 8'h7b));
    endfunction

    // Receiver stall pattern, with a long hold-off on request
    initial begin : receiver
        int style;
        int span;
        out_ch.ready <= 1'b0;
        @(negedge i_clk);
        forever begin
            style = $urandom_range(0, 2);
            span  = $urandom_range(5, 60);
            repeat (span) begin
                if (hold_req) begin
                    out_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    hold_req = 1'b0;
                end
                case (style)
                    0: begin
                        out_ch.ready <= 1'b1;
                    end
                    1: begin
                        out_ch.ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        out_ch.ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
                @(negedge i_clk);
            end
        end
    end

    // Run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int    seg;
        int    n_streams;
        int    len;
        int    random_start;
        t_mode seg_mode;
        in_ch.valid        <= 1'b0;
        in_ch.data_in      <= '0;
        in_ch.end_of_input <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.mode        <= MODE_ENCODE;
        i_rst_n            <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Encode: last byte at each block phase, byte extremes
        write_mode(MODE_ENCODE);
        send_char(8'hff, 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b1);
        send_char(8'hff, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'ha5, 1'b1);
        send_char(8'h5a, 1'b0);
        send_char(8'hc3, 1'b0);
        send_char(8'h3c, 1'b0);
        send_char(8'h96, 1'b1);
        // stream left open, cut off by the mode write
        send_char(8'h12, 1'b0);
        send_char(8'h34, 1'b0);

        // Decode: end without data, full group, chars above the range, bad chars
        write_mode(MODE_DECODE);
        send_char(8'h3c, 1'b1);
        send_char(8'h7b, 1'b0);
        send_char(8'hff, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h41, 1'b1);
        send_char(8'h3b, 1'b1);
        send_char(8'h50, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h60, 1'b0);
        send_char(8'h70, 1'b1);
        send_char(8'h45, 1'b0);
        send_char(8'h46, 1'b0);
        send_char(8'h47, 1'b1);

        // Random segments of whole streams, one mode each
        seg          = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (seg == 2)
                seg_mode = MODE_ENCODE;
            else
                seg_mode = $urandom_range(0, 1) ? MODE_DECODE : MODE_ENCODE;
            write_mode(seg_mode);
            // receiver holds off while the sender keeps going: input backs up
            if (seg == 2) begin
                hold_req   = 1'b1;
                burst_left = 60;
            end
            n_streams = $urandom_range(2, 10);
            repeat (n_streams) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    send_char(next_input(seg_mode), k == len - 1);
            end
            // sometimes leave a stream open across the mode write
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) send_char(next_input(seg_mode), 1'b0);
            seg++;
        end

        drain();
        repeat (SETTLE_CYCLES * 4) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
